// ----- design/rbfi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbfi_pkg
// Shared types and constants for the ray versus box face intersection core.
// ----------------------------------------------------------------------------
package rbfi_pkg;

   // default number of fraction bits in the fixed-point format
   localparam int FRAC_BITS_DEF = 16;

   // field widths
   localparam int COORD_W = 32;
   localparam int DIST_W  = 31;
   localparam int TOL_W   = 16;
   localparam int FACE_W  = 3;
   localparam int NFACE   = 6;
   localparam int NAXIS   = 3;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_TOL  = 3'd6;

   localparam logic [TOL_W-1:0] EDGE_TOL_RESET = 16'd7;

   // face codes: minus faces first, then plus faces
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd1;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd2;
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef logic [COORD_W-1:0] coord_type;

   // ray payload carried down the pipeline
   typedef struct packed {
      coord_type [NAXIS-1:0] org;
      coord_type [NAXIS-1:0] dir;
      logic [DIST_W-1:0]     best;
   } ray_type;

   // magnitude of a signed coordinate; the most negative value maps to 2^31
   function automatic coord_type coord_mag(input coord_type v);
      coord_type r;
      r = v[COORD_W-1] ? coord_type'(-v) : v;
      return r;
   endfunction

endpackage

// ----- design/rbfi_req_if.sv -----
// ----------------------------------------------------------------------------
// rbfi_req_if
// Request channel: one ray with its best distance so far.
// ----------------------------------------------------------------------------
interface rbfi_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] origin_x;
   logic [31:0] origin_y;
   logic [31:0] origin_z;
   logic [31:0] dir_x;
   logic [31:0] dir_y;
   logic [31:0] dir_z;
   logic [30:0] best_distance;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   best_distance, input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   best_distance, output ready);
endinterface

// ----- design/rbfi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rbfi_rsp_if
// Response channel: hit flag, nearest distance and hit face.
// ----------------------------------------------------------------------------
interface rbfi_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [30:0] distance;
   logic [2:0]  face;

   modport source (output valid, hit, distance, face, input ready);
   modport sink   (input valid, hit, distance, face, output ready);
endinterface

// ----- design/ray_box_face_intersect_core.sv -----
// ----------------------------------------------------------------------------
// ray_box_face_intersect_core
// Ray against axis-aligned box, six face planes, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one ray per request: origin, direction and the best hit
//   distance so far. rsp returns one result per request, in order: hit flag,
//   the new nearest distance (or the input distance on a miss) and the face.
//   Box corners and edge tolerance are written through the csr_ port while
//   the pipeline is empty; they are read live by the prep and bounds stages.
//   One request is taken every cycle while the output is not stalled: the
//   six plane distances come from six restoring dividers unrolled into 32
//   stages, one quotient bit per stage, followed by a multiply stage, an
//   add stage, a bounds compare stage and the output register that picks
//   the winning face.
//   When rsp.ready is low with a result waiting, the whole pipeline holds
//   and req.ready drops; nothing is lost or repeated. Bubbles travel as
//   cleared valid bits.
//   Reset (synchronous, active high) clears all valid bits and loads the
//   register defaults: box 0..1.0 on each axis, tolerance 7.
// ----------------------------------------------------------------------------
module ray_box_face_intersect_core #(
   parameter int FRAC_BITS = rbfi_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   rbfi_req_if.sink                         req,
   rbfi_rsp_if.source                       rsp,
   input  logic                             csr_wr_en,
   input  logic [rbfi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbfi_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import rbfi_pkg::*;

   localparam int QB = 32;                 // quotient bits, top one is overflow
   localparam int NW = COORD_W + 1 + FRAC_BITS; // scaled numerator width
   localparam int CW = NW + QB;            // divider compare width
   localparam int PW = DIST_W + COORD_W;   // product width
   localparam int SW = PW + 1;             // signed hit sum width
   localparam int BW = COORD_W + 2;        // widened bound width

   // ---------------------------------------------------------------------
   // configuration registers
   coord_type         box_min_ff [NAXIS];
   coord_type         box_max_ff [NAXIS];
   logic [TOL_W-1:0]  tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NAXIS; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= COORD_W'(64'(1) << FRAC_BITS);
         end
         tol_ff <= EDGE_TOL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_wr_data;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wr_data;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wr_data;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_wr_data;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wr_data;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wr_data;
            CSR_EDGE_TOL:  tol_ff        <= csr_wr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // global pipeline enable
   logic adv;
   logic out_valid_ff;

   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------------------------------------------------------------
   // prep: numerator, divisor and sign checks per face
   ray_type          ray_in;
   logic [NW-1:0]    prep_r_in [NFACE];
   coord_type        prep_d_in [NFACE];
   logic             prep_ok_in [NFACE];

   always_comb begin
      logic signed [COORD_W:0] num;
      logic [COORD_W:0]        magn;
      coord_type               corner;
      coord_type               dv;
      int                      f;
      ray_in.org[0] = req.origin_x;
      ray_in.org[1] = req.origin_y;
      ray_in.org[2] = req.origin_z;
      ray_in.dir[0] = req.dir_x;
      ray_in.dir[1] = req.dir_y;
      ray_in.dir[2] = req.dir_z;
      ray_in.best   = req.best_distance;
      for (int side = 0; side < 2; side++) begin
         for (int ax = 0; ax < NAXIS; ax++) begin
            f      = side * NAXIS + ax;
            corner = (side == 1) ? box_max_ff[ax] : box_min_ff[ax];
            dv     = ray_in.dir[ax];
            num    = $signed({corner[COORD_W-1], corner})
                     - $signed({ray_in.org[ax][COORD_W-1], ray_in.org[ax]});
            magn   = num[COORD_W] ? (COORD_W+1)'(-num) : num;
            prep_ok_in[f] = (dv != '0) && (num != '0) && (num[COORD_W] == dv[COORD_W-1]);
            prep_r_in[f]  = NW'(magn) << FRAC_BITS;
            prep_d_in[f]  = coord_mag(dv);
         end
      end
   end

   // ---------------------------------------------------------------------
   // divider pipeline: stage j settles quotient bit QB-1-j
   logic             div_v_ff  [QB+1];
   ray_type          div_ray_ff [QB+1];
   logic [NW-1:0]    div_r_ff  [QB+1][NFACE];
   coord_type        div_d_ff  [QB+1][NFACE];
   logic [QB-1:0]    div_q_ff  [QB+1][NFACE];
   logic             div_ok_ff [QB+1][NFACE];

   logic [NW-1:0]    div_r_in  [QB][NFACE];
   logic [QB-1:0]    div_q_in  [QB][NFACE];

   always_comb begin
      logic [CW-1:0] rem;
      logic [CW-1:0] dsh;
      for (int j = 0; j < QB; j++) begin
         for (int f = 0; f < NFACE; f++) begin
            rem = CW'(div_r_ff[j][f]);
            dsh = CW'(div_d_ff[j][f]) << (QB - 1 - j);
            if (rem >= dsh) begin
               div_r_in[j][f] = NW'(rem - dsh);
               div_q_in[j][f] = {div_q_ff[j][f][QB-2:0], 1'b1};
            end else begin
               div_r_in[j][f] = div_r_ff[j][f];
               div_q_in[j][f] = {div_q_ff[j][f][QB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QB; j++) begin
            div_v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         div_v_ff[0] <= req.valid;
         for (int j = 0; j < QB; j++) begin
            div_v_ff[j+1] <= div_v_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ray_ff[0] <= ray_in;
         for (int f = 0; f < NFACE; f++) begin
            div_r_ff[0][f]  <= prep_r_in[f];
            div_d_ff[0][f]  <= prep_d_in[f];
            div_q_ff[0][f]  <= '0;
            div_ok_ff[0][f] <= prep_ok_in[f];
         end
         for (int j = 0; j < QB; j++) begin
            div_ray_ff[j+1] <= div_ray_ff[j];
            for (int f = 0; f < NFACE; f++) begin
               div_r_ff[j+1][f]  <= div_r_in[j][f];
               div_d_ff[j+1][f]  <= div_d_ff[j][f];
               div_q_ff[j+1][f]  <= div_q_in[j][f];
               div_ok_ff[j+1][f] <= div_ok_ff[j][f];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // multiply: saturate distance, scale each direction by it
   logic              m_v_ff;
   ray_type           m_ray_ff;
   logic [DIST_W-1:0] m_dist_ff [NFACE];
   logic              m_ok_ff   [NFACE];
   logic [PW-1:0]     m_prod_ff [NFACE][NAXIS];

   logic [DIST_W-1:0] m_dist_in [NFACE];
   logic              m_ok_in   [NFACE];
   logic [PW-1:0]     m_prod_in [NFACE][NAXIS];

   always_comb begin
      for (int f = 0; f < NFACE; f++) begin
         m_dist_in[f] = div_q_ff[QB][f][QB-1] ? DIST_MAX : div_q_ff[QB][f][DIST_W-1:0];
         m_ok_in[f]   = div_ok_ff[QB][f] && (m_dist_in[f] != '0);
         for (int a = 0; a < NAXIS; a++) begin
            m_prod_in[f][a] = PW'(m_dist_in[f]) * PW'(coord_mag(div_ray_ff[QB].dir[a]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= div_v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ray_ff  <= div_ray_ff[QB];
         m_dist_ff <= m_dist_in;
         m_ok_ff   <= m_ok_in;
         m_prod_ff <= m_prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // add: hit coordinate before saturation
   logic              h_v_ff;
   logic [DIST_W-1:0] h_best_ff;
   logic [DIST_W-1:0] h_dist_ff [NFACE];
   logic              h_ok_ff   [NFACE];
   logic [SW-1:0]     h_sum_ff  [NFACE][NAXIS];
   logic [SW-1:0]     h_sum_in  [NFACE][NAXIS];

   always_comb begin
      logic [SW-1:0] sh;
      logic [SW-1:0] org;
      for (int f = 0; f < NFACE; f++) begin
         for (int a = 0; a < NAXIS; a++) begin
            sh  = SW'(m_prod_ff[f][a] >> FRAC_BITS);
            org = SW'($signed(m_ray_ff.org[a]));
            h_sum_in[f][a] = m_ray_ff.dir[a][COORD_W-1] ? (org - sh) : (org + sh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else if (adv) begin
         h_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_best_ff <= m_ray_ff.best;
         h_dist_ff <= m_dist_ff;
         h_ok_ff   <= m_ok_ff;
         h_sum_ff  <= h_sum_in;
      end
   end

   // ---------------------------------------------------------------------
   // bounds: saturate hit point, test against widened box
   logic              c_v_ff;
   logic [DIST_W-1:0] c_best_ff;
   logic [DIST_W-1:0] c_dist_ff [NFACE];
   logic              c_ok_ff   [NFACE];
   logic              c_ok_in   [NFACE];

   always_comb begin
      logic signed [SW-1:0] s;
      logic signed [BW-1:0] p;
      logic signed [BW-1:0] lo_b;
      logic signed [BW-1:0] hi_b;
      logic                 in_box;
      for (int f = 0; f < NFACE; f++) begin
         in_box = 1'b1;
         for (int a = 0; a < NAXIS; a++) begin
            s = $signed(h_sum_ff[f][a]);
            if (s > $signed(SW'(64'h7FFF_FFFF))) begin
               p = BW'(64'h7FFF_FFFF);
            end else if (s < -$signed(SW'(64'h8000_0000))) begin
               p = -$signed(BW'(64'h8000_0000));
            end else begin
               p = BW'(s);
            end
            lo_b = $signed(BW'($signed(box_min_ff[a]))) - $signed(BW'(tol_ff));
            hi_b = $signed(BW'($signed(box_max_ff[a]))) + $signed(BW'(tol_ff));
            if (!(p > lo_b && p < hi_b)) begin
               in_box = 1'b0;
            end
         end
         c_ok_in[f] = h_ok_ff[f] && in_box;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= h_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_best_ff <= h_best_ff;
         c_dist_ff <= h_dist_ff;
         c_ok_ff   <= c_ok_in;
      end
   end

   // ---------------------------------------------------------------------
   // select: faces in order, strict compare so ties keep the earlier face
   logic              out_hit_ff,  out_hit_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic [FACE_W-1:0] out_face_ff, out_face_in;

   always_comb begin
      out_hit_in  = 1'b0;
      out_dist_in = c_best_ff;
      out_face_in = FACE_NEG_X;
      for (int f = 0; f < NFACE; f++) begin
         if (c_ok_ff[f] && (c_dist_ff[f] < out_dist_in)) begin
            out_hit_in  = 1'b1;
            out_dist_in = c_dist_ff[f];
            out_face_in = FACE_W'(f);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff  <= out_hit_in;
         out_dist_ff <= out_dist_in;
         out_face_ff <= out_face_in;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.hit      = out_hit_ff;
   assign rsp.distance = out_dist_ff;
   assign rsp.face     = out_face_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray versus box face intersection core: rays go
// in on req, a scoreboard predicts hit, distance and face from its own copy
// of the box registers and checks every rsp in order, under random idling.
// ----------------------------------------------------------------------------
module tb_top;
   import rbfi_pkg::*;

   localparam int  FRAC     = FRAC_BITS_DEF;
   localparam int  PIPE_LAT = 36;
   localparam real UNIT     = 65536.0;

   typedef struct {
      logic              hit;
      logic [DIST_W-1:0] distance;
      logic [FACE_W-1:0] face;
   } box_hit_type;

   // Scoreboard: box registers, face predictor and the queue of pending hits
   class box_hit_board;
      longint      lo[3];
      longint      hi[3];
      longint      tol;
      box_hit_type pending[$];
      int          errors;

      function new();
         for (int a = 0; a < 3; a++) begin
            lo[a] = 0;
            hi[a] = longint'(1) << FRAC;
         end
         tol    = EDGE_TOL_RESET;
         errors = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
         longint s;
         s = longint'($signed(data));
         case (idx)
            CSR_BOX_MIN_X: lo[0] = s;
            CSR_BOX_MIN_Y: lo[1] = s;
            CSR_BOX_MIN_Z: lo[2] = s;
            CSR_BOX_MAX_X: hi[0] = s;
            CSR_BOX_MAX_Y: hi[1] = s;
            CSR_BOX_MAX_Z: hi[2] = s;
            CSR_EDGE_TOL:  tol   = longint'(data[TOL_W-1:0]);
            default: ;
         endcase
      endfunction

      // distance to a face plane, 0 when the plane is not ahead of the ray
      function longint plane_distance(input longint corner, input longint o,
                                      input longint d);
         longint          num;
         longint unsigned q;
         num = corner - o;
         if (d == 0 || num == 0) return 0;
         if ((num < 0) != (d < 0)) return 0;
         q = ((num < 0 ? -num : num) << FRAC) / (d < 0 ? -d : d);
         if (q > 64'd2147483647) q = 64'd2147483647;
         return longint'(q);
      endfunction

      // coordinate of the hit point on one axis, saturated to 32 bits
      function longint hit_coord(input longint o, input longint d, input longint span);
         longint unsigned p;
         longint          r;
         p = (longint'(span) * (d < 0 ? -d : d)) >> FRAC;
         r = o + (d < 0 ? -longint'(p) : longint'(p));
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r;
      endfunction

      function void note_ray(input ray_type r);
         longint      o[3];
         longint      d[3];
         longint      best;
         longint      plane_d;
         longint      p;
         bit          in_box;
         int          ax;
         box_hit_type e;
         for (int a = 0; a < 3; a++) begin
            o[a] = longint'($signed(r.org[a]));
            d[a] = longint'($signed(r.dir[a]));
         end
         best       = longint'(r.best);
         e.hit      = 1'b0;
         e.face     = FACE_NEG_X;
         // minus faces first, then plus faces; strict compare keeps earlier on ties
         for (int f = 0; f < NFACE; f++) begin
            ax      = f % 3;
            plane_d = plane_distance(f < 3 ? lo[ax] : hi[ax], o[ax], d[ax]);
            if (plane_d <= 0) continue;
            in_box = 1'b1;
            for (int a = 0; a < 3; a++) begin
               p = hit_coord(o[a], d[a], plane_d);
               if (!(p > lo[a] - tol && p < hi[a] + tol)) in_box = 1'b0;
            end
            if (in_box && plane_d < best) begin
               best   = plane_d;
               e.face = FACE_W'(f);
               e.hit  = 1'b1;
            end
         end
         e.distance = DIST_W'(best);
         pending.push_back(e);
      endfunction

      function void check_result(input logic hit, input logic [DIST_W-1:0] distance,
                                 input logic [FACE_W-1:0] face);
         box_hit_type e;
         if (pending.size() == 0) begin
            $error("unexpected response: hit %0b distance %0h face %0d",
                   hit, distance, face);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (hit !== e.hit) begin
            $error("hit: expected %0b actual %0b", e.hit, hit);
            errors++;
         end
         if (distance !== e.distance) begin
            $error("distance: expected %0h actual %0h", e.distance, distance);
            errors++;
         end
         if (face !== e.face) begin
            $error("face: expected %0d actual %0d", e.face, face);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   bit                    calm;
   box_hit_board          board;

   rbfi_req_if req_ch ();
   rbfi_rsp_if rsp_ch ();

   ray_box_face_intersect_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // record accepted requests and check accepted responses
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_ray({req_ch.origin_z, req_ch.origin_y, req_ch.origin_x,
                         req_ch.dir_z, req_ch.dir_y, req_ch.dir_x,
                         req_ch.best_distance});
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.hit, rsp_ch.distance, rsp_ch.face);
   end

   // response back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 38);
   end

   // one register write; the caller drops the write enable afterwards
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      board.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic write_box(input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] z0, input logic [31:0] x1,
                            input logic [31:0] y1, input logic [31:0] z1,
                            input logic [31:0] tol);
      write_reg(CSR_BOX_MIN_X, x0);
      write_reg(CSR_BOX_MIN_Y, y0);
      write_reg(CSR_BOX_MIN_Z, z0);
      write_reg(CSR_BOX_MAX_X, x1);
      write_reg(CSR_BOX_MAX_Y, y1);
      write_reg(CSR_BOX_MAX_Z, z1);
      write_reg(CSR_EDGE_TOL, tol);
      csr_wr_en <= 1'b0;
   endtask

   // present one ray and hold it until accepted
   task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [31:0] dx,
                           input logic [31:0] dy, input logic [31:0] dz,
                           input logic [30:0] best);
      while (!calm && $urandom_range(99) < 38) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.origin_x      <= ox;
      req_ch.origin_y      <= oy;
      req_ch.origin_z      <= oz;
      req_ch.dir_x         <= dx;
      req_ch.dir_y         <= dy;
      req_ch.dir_z         <= dz;
      req_ch.best_distance <= best;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop sending and let the pipeline empty out
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] fx(input real v);
      return 32'($rtoi(v * UNIT));
   endfunction

   function automatic logic [31:0] rand_dir();
      int k;
      k = $urandom_range(9);
      if (k == 0) return '0;
      if (k == 1) return $urandom;
      return $urandom_range(1 << 18, 1) * ($urandom_range(1) ? 1 : -1);
   endfunction

   function automatic logic [30:0] rand_best();
      int k;
      k = $urandom_range(3);
      if (k == 0) return DIST_MAX;
      if (k == 1) return 31'($urandom);
      return 31'($urandom_range(20 << 16));
   endfunction

   // random rays: mostly aimed near the box, the rest full-range noise
   task automatic random_rays(input int count);
      logic [31:0] o[3];
      logic [31:0] d[3];
      longint      c;
      for (int n = 0; n < count; n++) begin
         for (int a = 0; a < 3; a++) begin
            c    = (board.lo[a] + board.hi[a]) / 2;
            o[a] = 32'(c + longint'($signed(32'($urandom_range(1 << 19)))) - (1 << 18));
            d[a] = rand_dir();
         end
         // aim back toward the box center on most rays
         for (int a = 0; a < 3; a++)
            if ($urandom_range(3) != 0 && d[a] != 0)
               d[a] = ($signed(o[a]) > $signed(32'((board.lo[a] + board.hi[a]) / 2)))
                      ? -32'($urandom_range(1 << 17, 1)) : 32'($urandom_range(1 << 17, 1));
         if ($urandom_range(9) == 0) begin
            for (int a = 0; a < 3; a++) begin
               o[a] = $urandom;
               d[a] = $urandom;
            end
         end
         send_ray(o[0], o[1], o[2], d[0], d[1], d[2], rand_best());
      end
   endtask

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      board        = new();
      calm         = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.origin_x = '0;
      req_ch.origin_y = '0;
      req_ch.origin_z = '0;
      req_ch.dir_x    = '0;
      req_ch.dir_y    = '0;
      req_ch.dir_z    = '0;
      req_ch.best_distance = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rays against the reset box: every face, ties, extremes
      send_ray(fx(-1.0), fx(0.5), fx(0.5), fx(1.0), 0, 0, DIST_MAX);
      send_ray(fx(0.5), fx(-1.0), fx(0.5), 0, fx(1.0), 0, DIST_MAX);
      send_ray(fx(0.5), fx(0.5), fx(-1.0), 0, 0, fx(1.0), DIST_MAX);
      send_ray(fx(2.0), fx(0.5), fx(0.5), fx(-1.0), 0, 0, DIST_MAX);
      send_ray(fx(0.5), fx(2.0), fx(0.5), 0, fx(-1.0), 0, DIST_MAX);
      send_ray(fx(0.5), fx(0.5), fx(2.0), 0, 0, fx(-1.0), DIST_MAX);
      // inside the box: only plus faces ahead
      send_ray(fx(0.5), fx(0.5), fx(0.5), fx(0.25), fx(0.5), fx(1.0), DIST_MAX);
      // corner-on tie between -X and -Y
      send_ray(fx(-1.0), fx(-1.0), fx(0.5), fx(1.0), fx(1.0), 0, DIST_MAX);
      // best distance already nearer, and best of zero
      send_ray(fx(-1.0), fx(0.5), fx(0.5), fx(1.0), 0, 0, 31'(fx(1.0)));
      send_ray(fx(-1.0), fx(0.5), fx(0.5), fx(1.0), 0, 0, '0);
      // no direction at all
      send_ray(fx(-1.0), fx(0.5), fx(0.5), 0, 0, 0, DIST_MAX);
      // ray pointing away
      send_ray(fx(-1.0), fx(0.5), fx(0.5), fx(-1.0), 0, 0, DIST_MAX);
      // field extremes: saturating distances and hit points
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
               32'h0000_0001, 32'h0000_0001, DIST_MAX);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, DIST_MAX);
      send_ray(32'h8000_0000, fx(0.5), fx(0.5), 32'h7FFF_FFFF, 0, 0, DIST_MAX);
      send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555);
      // just outside the edge, within and beyond the tolerance
      send_ray(fx(-1.0), 32'(-6), fx(0.5), fx(1.0), 0, 0, DIST_MAX);
      send_ray(fx(-1.0), 32'(-7), fx(0.5), fx(1.0), 0, 0, DIST_MAX);
      drain();

      // inverted box with the largest tolerance
      write_box(fx(1.0), fx(1.0), fx(1.0), 0, 0, 0, 32'hFFFF);
      send_ray(fx(-1.0), fx(0.5), fx(0.5), fx(1.0), 0, 0, DIST_MAX);
      send_ray(fx(0.5), fx(0.5), fx(3.0), 0, 0, fx(-1.0), DIST_MAX);
      random_rays(60);
      drain();

      // widest possible box, zero tolerance
      write_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      random_rays(200);
      drain();

      // random boxes, one stretch without any idling
      for (int ph = 0; ph < 5; ph++) begin
         longint b0[3];
         longint b1[3];
         calm = (ph == 2);
         for (int a = 0; a < 3; a++) begin
            b0[a] = longint'($urandom_range(16 << 16)) - (8 << 16);
            b1[a] = b0[a] + $urandom_range(4 << 16, 1);
         end
         write_box(32'(b0[0]), 32'(b0[1]), 32'(b0[2]), 32'(b1[0]), 32'(b1[1]),
                   32'(b1[2]), $urandom_range(TOL_W == 16 ? 255 : 0));
         random_rays(230);
         drain();
      end
      calm = 1'b0;

      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
